// ===== rtl/unimodal_peak_search_top_assert.svh =====
// Assertion macros for the peak search block.
// They use the enclosing module's clk and rst_n.
`ifndef UNIMODAL_PEAK_SEARCH_TOP_ASSERT_SVH
`define UNIMODAL_PEAK_SEARCH_TOP_ASSERT_SVH

// Same-cycle implication.
`define UPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define UPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/ups_pkg.sv =====
`default_nettype none

package ups_pkg;

  localparam int OPCODE_W = 1;
  localparam int SAMPLE_W = 32;
  localparam int KIND_W   = 2;
  localparam int RINDEX_W = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_START = 1'b0,
    OP_REPLY = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROBE  = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_NODROP = 2'd2
  } kind_t;

  // request handed from the input register to the core
  typedef struct packed {
    logic                fire;
    op_t                 op;
    logic [SAMPLE_W-1:0] value;
  } ups_cmd_t;

  // result the core would produce for the held request
  typedef struct packed {
    logic                emit;
    kind_t               kind;
    logic [RINDEX_W-1:0] index;
    logic                busy;
  } ups_res_t;

endpackage

`default_nettype wire

// ===== rtl/ups_if.sv =====
`default_nettype none

interface ups_in_if import ups_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output opcode, output sample_value, input ready);
  modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

interface ups_out_if import ups_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [RINDEX_W-1:0] result_index;

  modport source (output valid, output result_kind, output result_index, input ready);
  modport sink   (input valid, input result_kind, input result_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/ups_core.sv =====
`default_nettype none

module ups_core import ups_pkg::*; #(
  parameter int INDEX_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ups_cmd_t cmd,
  output ups_res_t res
);

  localparam int EXP_BITS = $clog2(INDEX_BITS);

  typedef enum logic [2:0] {
    PH_IDLE, PH_EXP, PH_LEFT, PH_RIGHT, PH_MID
  } phase_t;

  typedef enum logic [1:0] {
    SL_NONE = 2'd0,
    SL_RISE = 2'd1,
    SL_FALL = 2'd2
  } slope_t;

  phase_t                phase_r, phase_nxt;
  slope_t                slope_r, slope_nxt;
  logic [EXP_BITS-1:0]   exp_r, exp_nxt;
  logic [VALUE_BITS-1:0] last_val_r, last_val_nxt;
  logic [VALUE_BITS-1:0] lv_r, lv_nxt;
  logic [VALUE_BITS-1:0] rv_r, rv_nxt;
  logic [INDEX_BITS-1:0] pt_before_r, pt_before_nxt;
  logic [INDEX_BITS-1:0] pt_two_r, pt_two_nxt;
  logic [INDEX_BITS-1:0] lo_r, lo_nxt;
  logic [INDEX_BITS-1:0] hi_r, hi_nxt;

  logic [VALUE_BITS-1:0] v;
  logic [INDEX_BITS-1:0] mid_cur;
  logic [INDEX_BITS-1:0] probe;
  logic [INDEX_BITS-1:0] next_probe;
  logic [EXP_BITS:0]     exp_inc;
  logic                  nodrop;
  logic                  rise;
  logic [INDEX_BITS-1:0] mv_lo, mv_hi;
  logic [INDEX_BITS:0]   exp_step, mv_step;
  logic                  emit;
  kind_t                 kind;
  logic [INDEX_BITS-1:0] ridx;

  // {narrow, mid} for a binary step over [lo, hi]
  function automatic logic [INDEX_BITS:0] bin_step(input logic [INDEX_BITS-1:0] lo,
                                                   input logic [INDEX_BITS-1:0] hi);
    logic [INDEX_BITS-1:0] span;
    span = hi - lo;
    return {(span <= INDEX_BITS'(2)), lo + (span >> 1)};
  endfunction

  assign v          = VALUE_BITS'(cmd.value);
  assign mid_cur    = lo_r + ((hi_r - lo_r) >> 1);
  assign probe      = INDEX_BITS'(1) << exp_r;
  assign exp_inc    = {1'b0, exp_r} + (EXP_BITS+1)'(1);
  assign nodrop     = (exp_inc >= (EXP_BITS+1)'(INDEX_BITS));
  assign next_probe = INDEX_BITS'(1) << exp_inc[EXP_BITS-1:0];
  assign exp_step   = bin_step(pt_two_r, probe);

  // bound move: right side of the slope rises when left < right
  assign rise     = (phase_r == PH_RIGHT) ? (lv_r < v) : (lv_r < rv_r);
  assign mv_lo    = rise ? mid_cur : lo_r;
  assign mv_hi    = rise ? hi_r : mid_cur;
  assign mv_step  = bin_step(mv_lo, mv_hi);

  always_comb begin
    phase_nxt     = phase_r;
    slope_nxt     = slope_r;
    exp_nxt       = exp_r;
    last_val_nxt  = last_val_r;
    lv_nxt        = lv_r;
    rv_nxt        = rv_r;
    pt_before_nxt = pt_before_r;
    pt_two_nxt    = pt_two_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    emit          = 1'b0;
    kind          = KIND_PROBE;
    ridx          = '0;

    if (cmd.op == OP_START) begin
      phase_nxt     = PH_EXP;
      slope_nxt     = SL_NONE;
      exp_nxt       = '0;
      last_val_nxt  = '0;
      lv_nxt        = '0;
      rv_nxt        = '0;
      pt_before_nxt = '0;
      pt_two_nxt    = '0;
      lo_nxt        = '0;
      hi_nxt        = '0;
      emit          = 1'b1;
      ridx          = INDEX_BITS'(1);
    end else begin
      case (phase_r)
        PH_EXP: begin
          emit = 1'b1;
          if ((exp_r != '0) && (last_val_r > v)) begin
            lo_nxt    = pt_two_r;
            hi_nxt    = probe;
            slope_nxt = SL_NONE;
            if (exp_step[INDEX_BITS]) begin
              phase_nxt = PH_IDLE;
              kind      = KIND_PEAK;
              ridx      = exp_step[INDEX_BITS-1:0];
            end else begin
              phase_nxt = PH_LEFT;
              ridx      = exp_step[INDEX_BITS-1:0] - INDEX_BITS'(1);
            end
          end else begin
            last_val_nxt  = v;
            pt_two_nxt    = pt_before_r;
            pt_before_nxt = probe;
            exp_nxt       = exp_inc[EXP_BITS-1:0];
            if (nodrop) begin
              phase_nxt = PH_IDLE;
              kind      = KIND_NODROP;
            end else begin
              ridx = next_probe;
            end
          end
        end
        PH_LEFT: begin
          lv_nxt    = v;
          phase_nxt = PH_RIGHT;
          emit      = 1'b1;
          ridx      = mid_cur + INDEX_BITS'(1);
        end
        PH_RIGHT, PH_MID: begin
          emit = 1'b1;
          if (phase_r == PH_RIGHT) begin
            rv_nxt = v;
          end
          if ((phase_r == PH_RIGHT) && (lv_r == v)) begin
            // flat top between the neighbors
            phase_nxt = PH_IDLE;
            kind      = KIND_PEAK;
            ridx      = mid_cur;
          end else if ((phase_r == PH_RIGHT) &&
                       (((lv_r < v) && (slope_r == SL_FALL)) ||
                        ((lv_r > v) && (slope_r == SL_RISE)))) begin
            // slope flipped: look at mid itself
            phase_nxt = PH_MID;
            ridx      = mid_cur;
          end else if ((phase_r == PH_MID) && (v > lv_r) && (v > rv_r)) begin
            phase_nxt = PH_IDLE;
            kind      = KIND_PEAK;
            ridx      = mid_cur;
          end else begin
            lo_nxt    = mv_lo;
            hi_nxt    = mv_hi;
            slope_nxt = rise ? SL_RISE : SL_FALL;
            if (mv_step[INDEX_BITS]) begin
              phase_nxt = PH_IDLE;
              kind      = KIND_PEAK;
              ridx      = mv_step[INDEX_BITS-1:0];
            end else begin
              phase_nxt = PH_LEFT;
              ridx      = mv_step[INDEX_BITS-1:0] - INDEX_BITS'(1);
            end
          end
        end
        default: begin
          emit = 1'b0;  // reply while idle is dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      slope_r     <= SL_NONE;
      exp_r       <= '0;
      last_val_r  <= '0;
      lv_r        <= '0;
      rv_r        <= '0;
      pt_before_r <= '0;
      pt_two_r    <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
    end else if (cmd.fire) begin
      phase_r     <= phase_nxt;
      slope_r     <= slope_nxt;
      exp_r       <= exp_nxt;
      last_val_r  <= last_val_nxt;
      lv_r        <= lv_nxt;
      rv_r        <= rv_nxt;
      pt_before_r <= pt_before_nxt;
      pt_two_r    <= pt_two_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
    end
  end

  assign res.emit  = emit;
  assign res.kind  = kind;
  assign res.index = RINDEX_W'(ridx);
  assign res.busy  = (phase_r != PH_IDLE);

endmodule

`default_nettype wire

// ===== rtl/unimodal_peak_search_top.sv =====
// Peak search sequencer: one request in, at most one result out.
// A request is held in the request register, then its result in the result register.
// Throughput: one request per cycle while the output is not stalled; the single
// core step between the request register and the result register sets that figure.
// Reset (rst_n low, synchronous): both registers empty, search idle, all
// search state zero.
`default_nettype none

`include "unimodal_peak_search_top_assert.svh"

module unimodal_peak_search_top import ups_pkg::*; #(
  parameter int INDEX_BITS = 32,
  parameter int VALUE_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  ups_in_if.sink     in_req,
  ups_out_if.source  out_res
);

  // request register
  logic                req_valid_r;
  op_t                 req_op_r;
  logic [SAMPLE_W-1:0] req_val_r;

  // result register
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [RINDEX_W-1:0] out_index_r;

  ups_cmd_t cmd;
  ups_res_t res;
  logic     req_adv;   // held request is processed this cycle
  logic     out_load;

  // A held request moves on when it produces nothing (reply while idle)
  // or the result register is free or being drained.
  assign req_adv  = req_valid_r && (!res.emit || !out_valid_r || out_res.ready);
  assign out_load = req_adv && res.emit;

  assign in_req.ready = !req_valid_r || req_adv;

  assign cmd.fire  = req_adv;
  assign cmd.op    = req_op_r;
  assign cmd.value = req_val_r;

  ups_core #(
    .INDEX_BITS (INDEX_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  // payload captured on accept; no reset needed
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_op_r  <= op_t'(in_req.opcode);
      req_val_r <= in_req.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= res.kind;
      out_index_r <= res.index;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.result_kind  = out_kind_r;
  assign out_res.result_index = out_index_r;

  // never overwrite a result that is still waiting
  `UPS_ASSERT_NOW(a_no_overwrite, out_load && out_valid_r, out_res.ready)

  // a start request always asks for index 1 next
  `UPS_ASSERT_NEXT(a_start_probe, req_adv && (req_op_r == OP_START),
                   out_valid_r && (out_kind_r == KIND_PROBE) && (out_index_r == RINDEX_W'(1)))

  // a final result leaves the search idle
  `UPS_ASSERT_NEXT(a_final_idle, out_load && (res.kind != KIND_PROBE), !res.busy)

endmodule

`default_nettype wire
